// File: design/blink_period_id_decoder_assert.svh
// ----------------------------------------------------------------------------
// Blink period ID decoder assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef BLINK_PERIOD_ID_DECODER_ASSERT_SVH
`define BLINK_PERIOD_ID_DECODER_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define BPID_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blink period id decoder: same-cycle check failed");

// antecedent holds -> consequent holds in the next cycle
`define BPID_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blink period id decoder: next-cycle check failed");

`endif

// File: design/bpid_pkg.sv
// ----------------------------------------------------------------------------
// bpid_pkg
// Widths, register indexes, commands and defaults of the blink period ID decoder.
// ----------------------------------------------------------------------------
package bpid_pkg;

   localparam int NUM_BINS_DEF    = 10;
   localparam int NUM_IDS_DEF     = 4;
   localparam int COUNT_WIDTH_DEF = 8;

   localparam int TS_W        = 32;
   localparam int BASE_W      = 24;
   localparam int THR_W       = 8;
   localparam int DECAY_W     = 3;
   localparam int ID_W        = 4;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 24;
   localparam int REQ_DATA_W  = 40;
   localparam int REQ_USER_W  = 1;
   localparam int RSP_DATA_W  = 8;

   localparam logic [BASE_W-1:0]  BASE_PERIOD_RST    = 24'd33333;
   localparam logic [THR_W-1:0]   BIN_THRESHOLD_RST  = 8'd4;
   localparam logic [THR_W-1:0]   PEAK_THRESHOLD_RST = 8'd4;
   localparam logic [DECAY_W-1:0] DECAY_PERIOD_RST   = 3'd4;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BASE_PERIOD    = 2'd0,
      CSR_BIN_THRESHOLD  = 2'd1,
      CSR_PEAK_THRESHOLD = 2'd2,
      CSR_DECAY_PERIOD   = 2'd3
   } csr_index_type;

   typedef enum logic {
      CMD_OBSERVE = 1'b0,
      CMD_START   = 1'b1
   } command_type;

endpackage

// File: design/blink_period_id_decoder.sv
// ----------------------------------------------------------------------------
// blink_period_id_decoder
// Start command: clears the histogram and loads the result. Plain observation:
// peak check, then result; a toggle first runs the bit-serial period divider,
// and a recomputed ID adds a bin scan and a division of the weighted sum.
// One transaction at a time; the next is taken as soon as the result is loaded.
// Reset (synchronous) restores the register defaults and clears the histogram.
// ----------------------------------------------------------------------------
module blink_period_id_decoder #(
   parameter int NUM_BINS    = bpid_pkg::NUM_BINS_DEF,
   parameter int NUM_IDS     = bpid_pkg::NUM_IDS_DEF,
   parameter int COUNT_WIDTH = bpid_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // led_on [0], timestamp [32:1], zero fill
   input  logic [bpid_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command [0]
   input  logic [bpid_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // id [3:0], id_valid [4], transition [5], bin_out_of_range [6], zero fill
   output logic [bpid_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_we,
   input  logic [bpid_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bpid_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import bpid_pkg::*;

   localparam int C        = COUNT_WIDTH;
   localparam int IDX_W    = $clog2(NUM_BINS);
   localparam int CMP_W    = (C > THR_W) ? C : THR_W;
   localparam int TOTAL_W  = C + IDX_W;
   localparam int WSUM_W   = C + $clog2(NUM_BINS * (NUM_BINS - 1) / 2 + 1);
   localparam int DIV_W    = (BASE_W > TOTAL_W) ? BASE_W : TOTAL_W;
   localparam int CNT_W    = $clog2(TS_W + 1);
   localparam logic [C-1:0] COUNT_MAX = {C{1'b1}};

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_T, S_BIN, S_MEAN, S_SCAN, S_MLOAD, S_DIV_M, S_MROUND, S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [BASE_W-1:0]   base_period_ff, base_period_in;
   logic [THR_W-1:0]    bin_thr_ff, bin_thr_in;
   logic [THR_W-1:0]    peak_thr_ff, peak_thr_in;
   logic [DECAY_W-1:0]  decay_ff, decay_in;
   logic                led_state_ff, led_state_in;
   logic [TS_W-1:0]     last_edge_ff, last_edge_in;
   logic [C-1:0]        bins_ff [NUM_BINS];
   logic [C-1:0]        bins_in [NUM_BINS];
   logic [C-1:0]        peak_ff, peak_in;
   logic [DECAY_W-1:0]  event_ff, event_in;
   logic [ID_W-1:0]     mean_ff, mean_in;
   logic                trans_ff, trans_in;
   logic                oob_ff, oob_in;
   logic [TS_W-1:0]     div_q_ff, div_q_in;
   logic [DIV_W-1:0]    div_r_ff, div_r_in;
   logic [DIV_W-1:0]    div_d_ff, div_d_in;
   logic [CNT_W-1:0]    div_cnt_ff, div_cnt_in;
   logic [IDX_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [WSUM_W-1:0]   wsum_ff, wsum_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                req_led;
   logic [TS_W-1:0]     req_ts;
   logic [TS_W-1:0]     elapsed;
   logic                accept;
   logic [DIV_W:0]      div_shift;
   logic [DIV_W:0]      div_diff;
   logic                div_ge;
   logic                div_round;
   logic                div_busy;
   logic [TS_W:0]       k_full;
   logic                q_zero;
   logic                bin_hit;
   logic [IDX_W-1:0]    bin_k;
   logic [C-1:0]        bin_inc;
   logic [DECAY_W:0]    event_next;
   logic                decay_hit;
   logic [C-1:0]        scan_cur;
   logic [C+IDX_W-1:0]  scan_prod;
   logic                scan_take;
   logic [CMP_W-1:0]    peak_cmp;
   logic [CMP_W-1:0]    peak_thr_cmp;
   logic [C-1:0]        bin_tmp;

   assign req_led    = req_tdata[0];
   assign req_ts     = req_tdata[TS_W:1];
   assign elapsed    = req_ts - last_edge_ff;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign div_shift = {div_r_ff, div_q_ff[TS_W-1]};
   assign div_diff  = div_shift - {1'b0, div_d_ff};
   assign div_ge    = div_shift >= {1'b0, div_d_ff};
   assign div_round = {div_r_ff, 1'b0} > {1'b0, div_d_ff};
   assign div_busy  = (state_ff == S_DIV_T) || (state_ff == S_DIV_M);

   assign q_zero  = (div_q_ff == '0);
   assign k_full  = {1'b0, div_q_ff} + (TS_W+1)'(div_round);
   assign bin_hit = q_zero || (k_full <= (TS_W+1)'(NUM_BINS));
   assign bin_k   = q_zero ? '0 : IDX_W'(k_full - (TS_W+1)'(1));
   assign bin_inc = (bins_ff[bin_k] == COUNT_MAX) ? COUNT_MAX : bins_ff[bin_k] + C'(1);

   assign event_next = {1'b0, event_ff} + (DECAY_W+1)'(1);
   assign decay_hit  = event_next > {1'b0, decay_ff};

   assign scan_cur  = bins_ff[scan_idx_ff];
   assign scan_prod = scan_cur * scan_idx_ff;
   assign scan_take = CMP_W'(scan_cur) > CMP_W'(bin_thr_ff);

   assign peak_cmp     = CMP_W'(peak_ff);
   assign peak_thr_cmp = CMP_W'(peak_thr_ff);

   always_comb begin
      state_in       = state_ff;
      base_period_in = base_period_ff;
      bin_thr_in     = bin_thr_ff;
      peak_thr_in    = peak_thr_ff;
      decay_in       = decay_ff;
      led_state_in   = led_state_ff;
      last_edge_in   = last_edge_ff;
      bins_in        = bins_ff;
      peak_in        = peak_ff;
      event_in       = event_ff;
      mean_in        = mean_ff;
      trans_in       = trans_ff;
      oob_in         = oob_ff;
      div_q_in       = div_q_ff;
      div_r_in       = div_r_ff;
      div_d_in       = div_d_ff;
      div_cnt_in     = div_cnt_ff;
      scan_idx_in    = scan_idx_ff;
      wsum_in        = wsum_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      bin_tmp        = '0;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_BASE_PERIOD:    base_period_in = csr_wdata[BASE_W-1:0];
            CSR_BIN_THRESHOLD:  bin_thr_in     = csr_wdata[THR_W-1:0];
            CSR_PEAK_THRESHOLD: peak_thr_in    = csr_wdata[THR_W-1:0];
            CSR_DECAY_PERIOD:   decay_in       = csr_wdata[DECAY_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff) inside
         S_IDLE: begin
            if (accept) begin
               trans_in = 1'b0;
               oob_in   = 1'b0;
               if (req_tuser[0] == CMD_START) begin
                  for (int l = 0; l < NUM_BINS; l++) begin
                     bins_in[l] = '0;
                  end
                  led_state_in = 1'b0;
                  peak_in      = '0;
                  event_in     = '0;
                  last_edge_in = req_ts;
                  state_in     = S_OUT;
               end else if (req_led != led_state_ff) begin
                  led_state_in = req_led;
                  trans_in     = 1'b1;
                  last_edge_in = req_ts;
                  if (base_period_ff == '0 || elapsed == '0) begin
                     oob_in   = 1'b1;
                     state_in = S_MEAN;
                  end else begin
                     div_q_in   = elapsed;
                     div_r_in   = '0;
                     div_d_in   = DIV_W'(base_period_ff);
                     div_cnt_in = CNT_W'(TS_W);
                     state_in   = S_DIV_T;
                  end
               end else begin
                  state_in = S_MEAN;
               end
            end
         end
         S_DIV_T, S_DIV_M: begin
            div_q_in   = {div_q_ff[TS_W-2:0], div_ge};
            div_r_in   = div_ge ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
            div_cnt_in = div_cnt_ff - CNT_W'(1);
            if (div_cnt_ff == CNT_W'(1)) begin
               state_in = (state_ff == S_DIV_T) ? S_BIN : S_MROUND;
            end
         end
         S_BIN: begin
            if (!bin_hit) begin
               oob_in = 1'b1;
            end else begin
               if (bin_inc > peak_ff) begin
                  peak_in = bin_inc;
               end
               for (int l = 0; l < NUM_BINS; l++) begin
                  bin_tmp = (IDX_W'(l) == bin_k) ? bin_inc : bins_ff[l];
                  if (decay_hit && bin_tmp != '0) begin
                     bin_tmp = bin_tmp - C'(1);
                  end
                  bins_in[l] = bin_tmp;
               end
               event_in = decay_hit ? '0 : event_next[DECAY_W-1:0];
            end
            state_in = S_MEAN;
         end
         S_MEAN: begin
            if (peak_cmp > peak_thr_cmp) begin
               scan_idx_in = '0;
               wsum_in     = '0;
               total_in    = '0;
               state_in    = S_SCAN;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SCAN: begin
            if (scan_take) begin
               wsum_in  = wsum_ff + WSUM_W'(scan_prod);
               total_in = total_ff + TOTAL_W'(scan_cur);
            end
            scan_idx_in = scan_idx_ff + IDX_W'(1);
            if (scan_idx_ff == IDX_W'(NUM_BINS - 1)) begin
               state_in = S_MLOAD;
            end
         end
         S_MLOAD: begin
            if (total_ff == '0) begin
               state_in = S_OUT;
            end else begin
               div_q_in   = TS_W'(wsum_ff) << (TS_W - WSUM_W);
               div_r_in   = '0;
               div_d_in   = DIV_W'(total_ff);
               div_cnt_in = CNT_W'(WSUM_W);
               state_in   = S_DIV_M;
            end
         end
         S_MROUND: begin
            mean_in  = div_q_ff[ID_W-1:0] + ID_W'(div_round);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, oob_ff, trans_ff, mean_ff < ID_W'(NUM_IDS), mean_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      div_d_ff    <= div_d_in;
      div_cnt_ff  <= div_cnt_in;
      scan_idx_ff <= scan_idx_in;
      wsum_ff     <= wsum_in;
      total_ff    <= total_in;
      rsp_data_ff <= rsp_data_in;
      trans_ff    <= trans_in;
      oob_ff      <= oob_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         base_period_ff <= BASE_PERIOD_RST;
         bin_thr_ff     <= BIN_THRESHOLD_RST;
         peak_thr_ff    <= PEAK_THRESHOLD_RST;
         decay_ff       <= DECAY_PERIOD_RST;
         led_state_ff   <= 1'b0;
         last_edge_ff   <= '0;
         for (int l = 0; l < NUM_BINS; l++) begin
            bins_ff[l] <= '0;
         end
         peak_ff        <= '0;
         event_ff       <= '0;
         mean_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         base_period_ff <= base_period_in;
         bin_thr_ff     <= bin_thr_in;
         peak_thr_ff    <= peak_thr_in;
         decay_ff       <= decay_in;
         led_state_ff   <= led_state_in;
         last_edge_ff   <= last_edge_in;
         bins_ff        <= bins_in;
         peak_ff        <= peak_in;
         event_ff       <= event_in;
         mean_ff        <= mean_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

`include "blink_period_id_decoder_assert.svh"

   `BPID_ASSERT_NXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `BPID_ASSERT_IMP(a_oob_needs_toggle, clock, reset, rsp_valid_ff && rsp_data_ff[6], rsp_data_ff[5])
   `BPID_ASSERT_IMP(a_divisor_nonzero, clock, reset, div_busy, div_d_ff != '0)
   `BPID_ASSERT_IMP(a_scan_needs_peak, clock, reset, state_ff == S_SCAN, peak_cmp > peak_thr_cmp)

endmodule
